/* design/lzss_decoder_4k_window_top_assert.svh */
// Assertion macros used by the decoder back end.
`ifndef LZSS_DECODER_4K_WINDOW_TOP_ASSERT_SVH
`define LZSS_DECODER_4K_WINDOW_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LZSSD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LZSSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LZSSD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define LZSSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* design/lzssd_pkg.sv */
// Types and constants of the LZSS decoder.
package lzssd_pkg;

   localparam int WIN_SIZE     = 4096;
   localparam int WIN_AW       = 12;
   localparam int DIST_W       = WIN_AW + 1;
   localparam int LEN_W        = 5;
   localparam int NIBBLE_SHIFT = 4;
   localparam int MIN_MATCH    = 2;
   localparam logic [8:0] FLAG_MARK = 9'h100;
   localparam logic [8:0] FLAG_EMPTY = 9'h001;
   localparam int CMD_DEPTH_DEF = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        has_data;
      logic        run_last;
      logic        stream_end;
      logic        truncated;
      logic [31:0] total_length;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_MATCH,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [7:0]        byte_val;
      logic [DIST_W-1:0] distance;
      logic [LEN_W-1:0]  len;
      logic              last;
      logic              cut;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LIT,
      BK_END,
      BK_RD,
      BK_WR
   } back_state_type;

endpackage

/* design/lzssd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lzssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/lzssd_cmd_queue.sv */
// Short command queue between the decoder front and back.
module lzssd_cmd_queue import lzssd_pkg::*; #(
   parameter int DEPTH = CMD_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enq,
   input  cmd_type      enq_data,
   input  logic         deq,
   output cmd_type      head,
   output q_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_enq, do_deq;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_enq = enq && !status.full;
   assign do_deq = deq && !status.empty;
   assign head   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + CW'(1);
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         mem_ff[wr_ptr_ff] <= enq_data;
      end
   end

endmodule

/* design/lzssd_front.sv */
// Decoder front: flag tracking and classification of stream bytes into commands.
module lzssd_front import lzssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         enq,
   output cmd_type      enq_data
);

   logic [8:0] flag_ff, flag_in;
   logic       await_ff, await_in;
   logic [7:0] held_ff, held_in;
   logic       fire;
   logic [DIST_W-1:0] raw_dist;

   assign fire     = push && !q_status.full;
   assign raw_dist = {1'b0, req_data.in_byte[3:0], held_ff};

   always_comb begin
      flag_in  = flag_ff;
      await_in = await_ff;
      held_in  = held_ff;
      enq      = 1'b0;
      enq_data.kind     = CMD_END;
      enq_data.byte_val = req_data.in_byte;
      enq_data.distance = (raw_dist == '0) ? DIST_W'(WIN_SIZE) : raw_dist;
      enq_data.len      = LEN_W'(req_data.in_byte >> NIBBLE_SHIFT) + LEN_W'(MIN_MATCH);
      enq_data.last     = req_data.in_last;
      enq_data.cut      = 1'b0;
      if (fire) begin
         if (await_ff) begin
            enq_data.kind = CMD_MATCH;
            enq      = 1'b1;
            await_in = 1'b0;
            flag_in  = flag_ff >> 1;
         end else if (flag_ff <= FLAG_EMPTY) begin
            // new flag byte, marker bit tells when all eight are used
            flag_in = FLAG_MARK | {1'b0, req_data.in_byte};
            enq     = req_data.in_last;
         end else if (flag_ff[0]) begin
            enq_data.kind = CMD_LIT;
            enq     = 1'b1;
            flag_in = flag_ff >> 1;
         end else begin
            held_in      = req_data.in_byte;
            await_in     = 1'b1;
            enq_data.cut = 1'b1;
            enq          = req_data.in_last;
         end
         if (req_data.in_last) begin
            flag_in  = FLAG_EMPTY;
            await_in = 1'b0;
            held_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= FLAG_EMPTY;
         await_ff <= 1'b0;
         held_ff  <= '0;
      end else begin
         flag_ff  <= flag_in;
         await_ff <= await_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* design/lzssd_back.sv */
// Decoder back: history window, match copy sequencer and result register.
`include "lzss_decoder_4k_window_top_assert.svh"
module lzssd_back import lzssd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      head,
   input  q_status_type q_status,
   output logic         deq,
   input  logic         pop,
   output logic         empty,
   output rsp_type      rsp_data
);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic              hit_ff, hit_in;
   logic [WIN_AW-1:0] wpos_ff, wpos_in;
   logic [DIST_W-1:0] filled_ff, filled_in;
   logic [31:0]       total_ff, total_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              out_free, emit, has_byte, final_beat, stream_end;
   logic [7:0]        byte_val, ram_rd_data;
   logic [31:0]       total_next;
   logic              ram_we, ram_re;
   logic [WIN_AW-1:0] ram_rd_addr;

   assign out_free = !rsp_valid_ff || pop;
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   lzssd_ram #(
      .WIDTH (8),
      .DEPTH (WIN_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wpos_ff),
      .wr_data (byte_val),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               case (head.kind)
                  CMD_LIT:   state_in = BK_LIT;
                  CMD_MATCH: state_in = BK_RD;
                  default:   state_in = BK_END;
               endcase
            end
         end
         BK_LIT, BK_END: begin
            if (out_free) state_in = BK_IDLE;
         end
         BK_RD: state_in = BK_WR;
         BK_WR: begin
            if (out_free) state_in = (remain_ff == LEN_W'(1)) ? BK_IDLE : BK_RD;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      deq          = (state_ff == BK_IDLE) && !q_status.empty;
      cmd_in       = deq ? head : cmd_ff;
      remain_in    = deq ? head.len : remain_ff;
      hit_in       = hit_ff;
      ram_re       = (state_ff == BK_RD);
      // distance 4096 wraps onto the write slot, i.e. a full window back
      ram_rd_addr  = wpos_ff - cmd_ff.distance[WIN_AW-1:0];
      if (ram_re) hit_in = (cmd_ff.distance <= filled_ff);

      emit       = out_free && ((state_ff == BK_LIT) || (state_ff == BK_WR) ||
                                (state_ff == BK_END));
      has_byte   = (state_ff != BK_END);
      byte_val   = (state_ff == BK_LIT) ? cmd_ff.byte_val :
                   (hit_ff ? ram_rd_data : 8'h00);
      final_beat = (state_ff != BK_WR) || (remain_ff == LEN_W'(1));
      stream_end = final_beat && cmd_ff.last;
      total_next = (has_byte && (total_ff != '1)) ? total_ff + 32'd1 : total_ff;
      ram_we     = emit && has_byte;

      rsp_in.out_byte     = has_byte ? byte_val : 8'h00;
      rsp_in.has_data     = has_byte;
      rsp_in.run_last     = final_beat;
      rsp_in.stream_end   = stream_end;
      rsp_in.truncated    = stream_end && cmd_ff.cut;
      rsp_in.total_length = stream_end ? total_next : 32'd0;

      wpos_in      = wpos_ff;
      filled_in    = filled_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (state_ff == BK_WR) remain_in = remain_ff - LEN_W'(1);
         if (has_byte) begin
            wpos_in   = wpos_ff + WIN_AW'(1);
            filled_in = (filled_ff < DIST_W'(WIN_SIZE)) ? filled_ff + DIST_W'(1) : filled_ff;
            total_in  = total_next;
         end
         if (stream_end) begin
            wpos_in   = '0;
            filled_in = '0;
            total_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wpos_ff      <= '0;
         filled_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         filled_ff    <= filled_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      remain_ff <= remain_in;
      hit_ff    <= hit_in;
      if (emit) rsp_ff <= rsp_in;
   end

   `LZSSD_ASSERT_ALWAYS(a_deq_nonempty, clock, reset, !deq || !q_status.empty, "deq on empty queue")
   `LZSSD_ASSERT_NEXT(a_rd_then_wr, clock, reset, state_ff == BK_RD, state_ff == BK_WR, "read not followed by write")
   `LZSSD_ASSERT_ALWAYS(a_filled_max, clock, reset, filled_ff <= DIST_W'(WIN_SIZE), "fill count past window")
   `LZSSD_ASSERT_ALWAYS(a_remain_live, clock, reset, !((state_ff == BK_RD) || (state_ff == BK_WR)) || (remain_ff != '0), "match copy with no bytes left")

endmodule

/* design/lzss_decoder_4k_window_top.sv */
// Top level of the streaming LZSS decoder with a 4096-byte history window.
//
//   channel | ports                          | beat
//   input   | push, full, req_data           | one compressed byte, last-byte mark
//   result  | pop, empty, rsp_data           | one decompressed byte or end marker
//
// Back end: a literal beat is emitted from its own state, a match takes a window read then a write
// for each of its 2..17 bytes; the single-port-read window RAM sets the copy rate.
// Flag and first match bytes enqueue no command unless they carry the last-byte mark.
// The front takes a byte every cycle until the command queue fills.
// Synchronous reset clears control state; the window RAM is not cleared, a fill
// count makes reads of unwritten slots return zero.
// A stalled result holds in the output register while the back end waits.
module lzss_decoder_4k_window_top import lzssd_pkg::*; #(
   parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         enq, deq;
   cmd_type      enq_data, head;

   assign full = q_status.full;

   lzssd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .q_status (q_status),
      .enq      (enq),
      .enq_data (enq_data)
   );

   lzssd_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .enq_data (enq_data),
      .deq      (deq),
      .head     (head),
      .status   (q_status)
   );

   lzssd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .deq      (deq),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the 4K-window LZSS decoder: directed rows, then random streams.
module tb_top;
   import lzssd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIR_ROWS    = 24;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 20000;
   localparam int RAND_BEATS  = 580;
   localparam int LONG_BYTES  = 4160;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       use_typed;
      rsp_type    typed;
   } dir_row_type;

   typedef enum logic [1:0] {
      DRAIN_ALL,
      COIN_FLIP,
      EVERY_FOURTH,
      TRICKLE
   } pop_style_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   lzss_decoder_4k_window_top u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   // decoder state as the predictor sees it
   logic [7:0]  win_mem [WIN_SIZE];
   logic [11:0] win_wp;
   logic [12:0] win_fill;
   logic [31:0] out_total;
   logic [8:0]  flag_sr;
   logic        need_hi;
   logic [7:0]  lo_hold;

   rsp_type     step_q[$];
   rsp_type     exp_q[$];
   dir_row_type dir_tab [DIR_ROWS];

   int cycles     = 0;
   int err_cnt    = 0;
   int beats_in   = 0;
   int beats_out  = 0;
   int n_streams  = 0;
   int n_cut      = 0;
   int max_stream = 0;
   int full_back  = 0;

   int burst_left  = 0;
   int no_gap_left = 0;

   logic          hold_ask   = 1'b0;
   logic          hold_done  = 1'b0;
   int            hold_left  = 0;
   int            phase_left = 0;
   pop_style_type pop_style  = DRAIN_ALL;

   function automatic void restart_stream();
      win_wp    = '0;
      win_fill  = '0;
      out_total = '0;
      flag_sr   = FLAG_EMPTY;
      need_hi   = 1'b0;
      lo_hold   = '0;
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      rsp_type r;
      win_mem[win_wp] = b;
      win_wp = win_wp + 12'd1;
      if (win_fill < 13'(WIN_SIZE)) win_fill = win_fill + 13'd1;
      if (out_total != 32'hFFFF_FFFF) out_total = out_total + 32'd1;
      r = '0;
      r.out_byte = b;
      r.has_data = 1'b1;
      step_q = {step_q, r};
   endfunction

   // Works out the output beats one compressed byte causes, into step_q.
   function automatic void decode_beat(input req_type d);
      logic [12:0] back_dist;
      logic [11:0] rd_ptr;
      int          run_len;
      int          i;
      logic        cut;
      rsp_type     r;
      step_q.delete();
      cut = 1'b0;
      if (need_hi) begin
         back_dist = {1'b0, d.in_byte[3:0], lo_hold};
         if (back_dist == 13'd0) back_dist = 13'(WIN_SIZE);
         if (back_dist == 13'(WIN_SIZE) && win_fill == 13'(WIN_SIZE)) full_back++;
         run_len = int'(d.in_byte[7:4]) + MIN_MATCH;
         for (i = 0; i < run_len; i++) begin
            rd_ptr = win_wp - back_dist[11:0];
            emit_byte((back_dist <= win_fill) ? win_mem[rd_ptr] : 8'h00);
         end
         need_hi = 1'b0;
         flag_sr = flag_sr >> 1;
      end else if (flag_sr <= FLAG_EMPTY) begin
         flag_sr = FLAG_MARK | {1'b0, d.in_byte};
      end else if (flag_sr[0]) begin
         emit_byte(d.in_byte);
         flag_sr = flag_sr >> 1;
      end else begin
         lo_hold = d.in_byte;
         need_hi = 1'b1;
         cut     = 1'b1;
      end
      if (d.in_last && step_q.size() == 0) begin
         r = '0;
         step_q = {step_q, r};
      end
      if (step_q.size() != 0) begin
         r = step_q[step_q.size() - 1];
         r.run_last = 1'b1;
         if (d.in_last) begin
            r.stream_end   = 1'b1;
            r.truncated    = cut;
            r.total_length = out_total;
         end
         step_q[step_q.size() - 1] = r;
      end
      if (d.in_last) begin
         n_streams++;
         if (cut) n_cut++;
         if (int'(out_total) > max_stream) max_stream = int'(out_total);
         restart_stream();
      end
   endfunction

   function automatic rsp_type lit_out(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.out_byte = b;
      r.has_data = 1'b1;
      r.run_last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type end_out(input logic cut, input logic [31:0] total);
      rsp_type r;
      r = '0;
      r.run_last     = 1'b1;
      r.stream_end   = 1'b1;
      r.truncated    = cut;
      r.total_length = total;
      return r;
   endfunction

   function automatic req_type beat_of(input logic [7:0] b);
      req_type t;
      t.in_byte = b;
      t.in_last = 1'b0;
      return t;
   endfunction

   // Offers one beat, predicts once it is taken, then paces the next one.
   task automatic send_beat(input req_type d, input logic use_typed, input rsp_type typed);
      push     <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (full);
      beats_in++;
      decode_beat(d);
      if (use_typed) exp_q = {exp_q, typed};
      else exp_q = {exp_q, step_q};
      if (no_gap_left > 0) begin
         no_gap_left--;
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   // One stream of flag groups with random content; short ones may be cut anywhere.
   // The long one is all longest matches, just enough to wrap the window.
   task automatic play_stream(input logic go_long, input int n_groups);
      req_type     toks[$];
      req_type     t;
      logic [7:0]  flags;
      logic [11:0] back_dist;
      logic [3:0]  len_nib;
      int          est;
      int          g;
      int          k;
      int          cut_at;
      est = 0;
      g   = 0;
      while (go_long ? (est < LONG_BYTES) : (g < n_groups)) begin
         if (go_long) flags = 8'h00;
         else flags = 8'($urandom);
         toks = {toks, beat_of(flags)};
         for (k = 0; k < 8; k++) begin
            if (flags[k]) begin
               toks = {toks, beat_of(8'($urandom))};
               est++;
            end else begin
               case ($urandom_range(0, 7))
                  0:       back_dist = 12'd0;
                  1:       back_dist = 12'($urandom);
                  2:       back_dist = 12'($urandom_range(1000, 4095));
                  default: back_dist = 12'($urandom_range(1, 40));
               endcase
               len_nib = go_long ? 4'd15 : 4'($urandom_range(0, 15));
               toks = {toks, beat_of(back_dist[7:0])};
               toks = {toks, beat_of({len_nib, back_dist[11:8]})};
               est += int'(len_nib) + MIN_MATCH;
            end
         end
         g++;
      end
      if (!go_long && $urandom_range(0, 3) == 0) begin
         cut_at = $urandom_range(0, toks.size() - 1);
         toks = toks[0:cut_at];
      end
      t = toks[toks.size() - 1];
      t.in_last = 1'b1;
      toks[toks.size() - 1] = t;
      foreach (toks[i]) send_beat(toks[i], 1'b0, '0);
   endtask

   function automatic void note_err(input string what, input rsp_type want, input rsp_type got);
      err_cnt++;
      if (err_cnt <= 10) begin
         $display("tb: %s at output beat %0d", what, beats_out);
         $display("   want byte=%h data=%b run_last=%b end=%b trunc=%b total=%0d",
                  want.out_byte, want.has_data, want.run_last, want.stream_end,
                  want.truncated, want.total_length);
         $display("   got  byte=%h data=%b run_last=%b end=%b trunc=%b total=%0d",
                  got.out_byte, got.has_data, got.run_last, got.stream_end,
                  got.truncated, got.total_length);
      end
   endfunction

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("tb: timeout after %0d cycles, %0d beats still expected", cycles, exp_q.size());
      $display("tb: failure");
      $finish;
   end

   // output checker
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (exp_q.size() == 0) begin
            note_err("unexpected output beat", '0, rsp_data);
         end else begin
            if (rsp_data !== exp_q[0]) note_err("mismatch", exp_q[0], rsp_data);
            void'(exp_q.pop_front());
         end
         beats_out++;
      end
   end

   // receiver: phases of different pop patterns, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else if (hold_ask && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         pop       <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            pop_style  <= pop_style_type'($urandom_range(0, 3));
            phase_left <= $urandom_range(8, 80);
         end else begin
            phase_left <= phase_left - 1;
         end
         case (pop_style)
            DRAIN_ALL:    pop <= 1'b1;
            COIN_FLIP:    pop <= 1'($urandom_range(0, 1));
            EVERY_FOURTH: pop <= (cycles % 4 == 0);
            default:      pop <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin
      int drain;
      restart_stream();
      dir_tab = '{
         '{8'h0B, 1'b0, 1'b0, '0},                // flag: lit lit match lit match x4
         '{8'h00, 1'b0, 1'b1, lit_out(8'h00)},
         '{8'hFF, 1'b0, 1'b1, lit_out(8'hFF)},
         '{8'h01, 1'b0, 1'b0, '0},                // distance 1, length 17: overlapping copy
         '{8'hF0, 1'b0, 1'b0, '0},
         '{8'hA5, 1'b0, 1'b1, lit_out(8'hA5)},
         '{8'h00, 1'b0, 1'b0, '0},                // distance zero: full window back
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},                // distance 4095, nothing written there yet
         '{8'h0F, 1'b0, 1'b0, '0},
         '{8'h02, 1'b0, 1'b0, '0},
         '{8'h10, 1'b0, 1'b0, '0},
         '{8'h05, 1'b0, 1'b0, '0},
         '{8'h20, 1'b0, 1'b0, '0},
         '{8'h00, 1'b1, 1'b1, end_out(1'b0, 32'd31)}, // stream ends on a flag byte
         '{8'h00, 1'b0, 1'b0, '0},
         '{8'h12, 1'b1, 1'b1, end_out(1'b1, 32'd0)},  // match missing its second byte
         '{8'h01, 1'b0, 1'b0, '0},
         '{8'h5A, 1'b0, 1'b1, lit_out(8'h5A)},
         '{8'h01, 1'b0, 1'b0, '0},
         '{8'hF0, 1'b1, 1'b0, '0},                // stream ends with a match
         '{8'h80, 1'b1, 1'b1, end_out(1'b0, 32'd0)},  // one-byte stream
         '{8'h01, 1'b0, 1'b0, '0},
         '{8'h3C, 1'b1, 1'b0, '0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         req_type t;
         t.in_byte = dir_tab[i].data;
         t.in_last = dir_tab[i].last;
         send_beat(t, dir_tab[i].use_typed, dir_tab[i].typed);
      end
      push <= 1'b0;
      do @(posedge clock); while (exp_q.size() != 0);

      // long stream that wraps the window; receiver holds off while it starts
      hold_ask    <= 1'b1;
      no_gap_left  = 150;
      play_stream(1'b1, 0);
      while (beats_in < RAND_BEATS) play_stream(1'b0, $urandom_range(1, 6));
      push <= 1'b0;

      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (exp_q.size() != 0 && drain < DRAIN_LIMIT);
      repeat (80) @(posedge clock);
      if (exp_q.size() != 0) begin
         err_cnt++;
         $display("tb: %0d expected output beats never arrived", exp_q.size());
      end

      $display("tb: %0d compressed beats in %0d streams (%0d cut mid-match), %0d output beats",
               beats_in, n_streams, n_cut, beats_out);
      $display("tb: longest stream %0d bytes, %0d full-window reads with a filled window",
               max_stream, full_back);
      if (err_cnt == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d errors", err_cnt);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
